// File: src/cfr_pkg.sv
// shared types and constants for the channel frame receiver
package cfr_pkg;

	localparam int BYTE_W     = 8;
	localparam int CHAN_W     = 4;
	localparam int LEN_W      = 12;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int EN_BITS    = 4;

	localparam logic [BYTE_W-1:0] MARKER_RESET  = 8'h7E;
	localparam logic [EN_BITS-1:0] ENABLE_RESET = 4'h0;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET  = 12'hFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARKER  = 2'd0,
		REG_CH_EN   = 2'd1,
		REG_MAX_LEN = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_STX  = 3'd0,
		PH_HDR  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_ETX  = 3'd4
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		K_PAYLOAD  = 3'd0,
		K_OK       = 3'd1,
		K_NO_ETX   = 3'd2,
		K_BAD_CH   = 3'd3,
		K_DISABLED = 3'd4,
		K_TOO_LONG = 3'd5
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  marker;
		logic [EN_BITS-1:0] chan_en;
		logic [LEN_W-1:0]   max_len;
	} cfg_t;

	typedef struct packed {
		logic              emit;
		kind_t             kind;
		logic [CHAN_W-1:0] chan;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
	} result_t;

endpackage

// File: src/cfr_deframer.sv
// frame state machine: decides the result for one byte and updates the frame state
module cfr_deframer #(
	parameter int MAX_CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [cfr_pkg::BYTE_W-1:0]  rx_byte,
	input  cfr_pkg::cfg_t               cfg,
	output cfr_pkg::result_t            res
);

	localparam logic [cfr_pkg::CHAN_W:0] CH_LIMIT = (cfr_pkg::CHAN_W+1)'(MAX_CHANNELS);

	cfr_pkg::phase_t              phase_q, phase_d;
	logic [cfr_pkg::CHAN_W-1:0]   chan_q, chan_d;
	logic [cfr_pkg::LEN_W-1:0]    len_q, len_d;
	logic [cfr_pkg::LEN_W-1:0]    cnt_q, cnt_d;

	logic                         is_marker;
	logic [cfr_pkg::CHAN_W-1:0]   hdr_chan;
	logic [cfr_pkg::LEN_W-1:0]    hdr_len;
	logic [cfr_pkg::LEN_W-1:0]    full_len;
	logic [cfr_pkg::LEN_W-1:0]    cnt_inc;
	logic                         bad_chan;
	logic                         chan_on;

	assign is_marker = (rx_byte == cfg.marker);
	assign hdr_chan  = rx_byte[7:4];
	assign hdr_len   = {rx_byte[3:0], 8'h00};
	assign full_len  = {len_q[11:8], rx_byte};
	assign cnt_inc   = cnt_q + 12'd1;
	assign bad_chan  = ({1'b0, hdr_chan} >= CH_LIMIT);
	// only the low channels have an enable bit
	assign chan_on   = (hdr_chan[3:2] == 2'b00) && cfg.chan_en[hdr_chan[1:0]];

	// next state
	always_comb begin
		phase_d = phase_q;
		chan_d  = chan_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		case (phase_q)
			cfr_pkg::PH_STX: begin
				if (is_marker) begin
					cnt_d   = '0;
					phase_d = cfr_pkg::PH_HDR;
				end
			end
			cfr_pkg::PH_HDR: begin
				// repeated marker is skipped
				if (!is_marker) begin
					chan_d = hdr_chan;
					len_d  = hdr_len;
					if (!bad_chan && chan_on) phase_d = cfr_pkg::PH_LEN;
					else phase_d = cfr_pkg::PH_STX;
				end
			end
			cfr_pkg::PH_LEN: begin
				len_d = full_len;
				if (full_len > cfg.max_len) begin
					phase_d = cfr_pkg::PH_STX;
				end else begin
					cnt_d   = '0;
					phase_d = (full_len == '0) ? cfr_pkg::PH_ETX : cfr_pkg::PH_DATA;
				end
			end
			cfr_pkg::PH_DATA: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= len_q) phase_d = cfr_pkg::PH_ETX;
			end
			cfr_pkg::PH_ETX: begin
				cnt_d   = '0;
				phase_d = cfr_pkg::PH_STX;
			end
			default: begin
				phase_d = cfr_pkg::PH_STX;
			end
		endcase
	end

	// result for this byte
	always_comb begin
		res.emit = 1'b0;
		res.kind = cfr_pkg::K_PAYLOAD;
		res.chan = chan_d;
		res.data = '0;
		res.len  = len_d;
		case (phase_q)
			cfr_pkg::PH_HDR: begin
				if (!is_marker) begin
					if (bad_chan) begin
						res.emit = 1'b1;
						res.kind = cfr_pkg::K_BAD_CH;
					end else if (!chan_on) begin
						res.emit = 1'b1;
						res.kind = cfr_pkg::K_DISABLED;
					end
				end
			end
			cfr_pkg::PH_LEN: begin
				if (full_len > cfg.max_len) begin
					res.emit = 1'b1;
					res.kind = cfr_pkg::K_TOO_LONG;
				end
			end
			cfr_pkg::PH_DATA: begin
				res.emit = 1'b1;
				res.kind = cfr_pkg::K_PAYLOAD;
				res.data = rx_byte;
			end
			cfr_pkg::PH_ETX: begin
				res.emit = 1'b1;
				res.kind = is_marker ? cfr_pkg::K_OK : cfr_pkg::K_NO_ETX;
			end
			default: begin
				res.emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfr_pkg::PH_STX;
			chan_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			chan_q  <= chan_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: src/channel_frame_receiver.sv
// channel frame receiver top level: config registers, input register, result register
// Takes one received byte per cycle while results are taken: the byte is held in an
// input register, the frame state machine decides on it combinationally and the outcome
// lands in the result register. A new byte is taken every cycle as long as results are
// taken; while the result register is full and stalled, bytes that give no result still
// pass through and a byte that gives a result waits in the input register. Each payload
// byte comes out with its channel and the header length, and every frame ends with one
// status transaction (frame good, end marker missing, bad channel, channel disabled or
// length too long). Registers must be written only while the block is idle; the block
// itself does not enforce this.
module channel_frame_receiver #(
	parameter int MAX_CHANNELS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [cfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cfr_pkg::BYTE_W-1:0]      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cfr_pkg::KIND_W-1:0]      result_kind,
	output logic [cfr_pkg::CHAN_W-1:0]      frame_channel,
	output logic [cfr_pkg::BYTE_W-1:0]      payload_byte,
	output logic [cfr_pkg::LEN_W-1:0]       frame_length
);

	cfr_pkg::cfg_t               cfg_q;
	logic                        valid_s1;
	logic [cfr_pkg::BYTE_W-1:0]  byte_s1;
	logic                        out_valid_q;
	cfr_pkg::kind_t              kind_q;
	logic [cfr_pkg::CHAN_W-1:0]  chan_q;
	logic [cfr_pkg::BYTE_W-1:0]  data_q;
	logic [cfr_pkg::LEN_W-1:0]   len_q;
	cfr_pkg::result_t            res;
	logic                        out_free;
	logic                        advance;
	logic                        in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.marker  <= cfr_pkg::MARKER_RESET;
			cfg_q.chan_en <= cfr_pkg::ENABLE_RESET;
			cfg_q.max_len <= cfr_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cfr_pkg::REG_MARKER:  cfg_q.marker  <= cfg_data[cfr_pkg::BYTE_W-1:0];
				cfr_pkg::REG_CH_EN:   cfg_q.chan_en <= cfg_data[cfr_pkg::EN_BITS-1:0];
				cfr_pkg::REG_MAX_LEN: cfg_q.max_len <= cfg_data[cfr_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cfr_deframer #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	// a byte with no result never waits on the output side
	assign advance  = valid_s1 && (!res.emit || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			kind_q <= res.kind;
			chan_q <= res.chan;
			data_q <= res.data;
			len_q  <= res.len;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign frame_channel = chan_q;
	assign payload_byte  = data_q;
	assign frame_length  = len_q;

endmodule

// File: test/channel_frame_receiver_tb.sv
// testbench for the channel frame receiver: random framed byte streams checked against a predictor
`timescale 1ns / 100ps

module channel_frame_receiver_tb;
	import cfr_pkg::*;

	localparam int NUM_CHANNELS  = 4;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_CYCLES  = 10;
	localparam int LIMIT_CYCLES  = 1500000;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		FEED_BYTE,
		FEED_CFG,
		FEED_DRAIN
	} feed_op_t;

	typedef struct packed {
		feed_op_t              op;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
	} feed_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAN_W-1:0] chan;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
	} frame_evt_t;

	typedef enum logic [1:0] {
		CUT_HEADER,
		CUT_LENGTH,
		FULL_GOOD_END,
		FULL_BAD_END
	} frame_cut_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [BYTE_W-1:0]     rx_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [KIND_W-1:0]     result_kind;
	logic [CHAN_W-1:0]     frame_channel;
	logic [BYTE_W-1:0]     payload_byte;
	logic [LEN_W-1:0]      frame_length;

	channel_frame_receiver #(
		.MAX_CHANNELS(NUM_CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.frame_channel(frame_channel),
		.payload_byte(payload_byte),
		.frame_length(frame_length)
	);

	// predictor state and its copy of the registers
	logic [BYTE_W-1:0]  cur_marker = MARKER_RESET;
	logic [EN_BITS-1:0] cur_enable = ENABLE_RESET;
	logic [LEN_W-1:0]   cur_max_len = MAX_LEN_RESET;
	phase_t             link_phase = PH_STX;
	logic [CHAN_W-1:0]  hdr_channel = '0;
	logic [LEN_W-1:0]   hdr_length = '0;
	logic [LEN_W-1:0]   payload_count = '0;

	frame_evt_t expected_deframed[$];
	feed_item_t link_feed[$];

	// register values as the stimulus generator sees them
	logic [BYTE_W-1:0]  gen_marker = MARKER_RESET;
	logic [EN_BITS-1:0] gen_en = ENABLE_RESET;
	logic [LEN_W-1:0]   gen_max = MAX_LEN_RESET;

	int  bytes_queued = 0;
	int  mismatches = 0;
	int  cycle_count = 0;
	int  send_gap = 0;
	int  settle = 0;
	int  stall_left = 0;
	bit  in_calm = 1'b0;
	bit  out_calm = 1'b0;
	bit  in_fire = 1'b0;

	feed_item_t head;
	frame_evt_t got_evt;
	logic       nx_valid;
	logic [7:0] nx_byte;
	logic       nx_wr;

	function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
		frame_evt_t ev;
		logic       hit;
		logic       emit;
		hit = (b == cur_marker);
		emit = 1'b0;
		ev.data = '0;
		ev.kind = K_PAYLOAD;
		case (link_phase)
			PH_STX: begin
				if (hit) begin
					payload_count = '0;
					link_phase = PH_HDR;
				end
			end
			PH_HDR: begin
				// a repeated marker keeps us waiting for the header
				if (!hit) begin
					hdr_channel = b[7:4];
					hdr_length = {b[3:0], 8'h00};
					emit = 1'b1;
					link_phase = PH_STX;
					if (hdr_channel >= NUM_CHANNELS) begin
						ev.kind = K_BAD_CH;
					end else if (hdr_channel < EN_BITS && cur_enable[hdr_channel[1:0]]) begin
						emit = 1'b0;
						link_phase = PH_LEN;
					end else begin
						ev.kind = K_DISABLED;
					end
				end
			end
			PH_LEN: begin
				hdr_length = hdr_length | {4'h0, b};
				if (hdr_length > cur_max_len) begin
					link_phase = PH_STX;
					emit = 1'b1;
					ev.kind = K_TOO_LONG;
				end else begin
					payload_count = '0;
					link_phase = (hdr_length == '0) ? PH_ETX : PH_DATA;
				end
			end
			PH_DATA: begin
				payload_count = payload_count + 12'd1;
				if (payload_count >= hdr_length)
					link_phase = PH_ETX;
				emit = 1'b1;
				ev.kind = K_PAYLOAD;
				ev.data = b;
			end
			PH_ETX: begin
				// the end slot byte is consumed even when it is not the marker
				payload_count = '0;
				link_phase = PH_STX;
				emit = 1'b1;
				if (hit)
					ev.kind = K_OK;
				else
					ev.kind = K_NO_ETX;
			end
			default: link_phase = PH_STX;
		endcase
		if (emit) begin
			ev.chan = hdr_channel;
			ev.len = hdr_length;
			expected_deframed.push_back(ev);
		end
	endfunction

	function automatic void push_byte(input logic [BYTE_W-1:0] b);
		link_feed.push_back({FEED_BYTE, 2'd0, 4'd0, b});
		bytes_queued++;
	endfunction

	function automatic void push_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] v);
		link_feed.push_back({FEED_CFG, idx, v});
		case (idx)
			REG_MARKER: gen_marker = v[BYTE_W-1:0];
			REG_CH_EN: gen_en = v[EN_BITS-1:0];
			REG_MAX_LEN: gen_max = v;
			default: ;
		endcase
	endfunction

	function automatic void push_drain();
		link_feed.push_back({FEED_DRAIN, 2'd0, 12'd0});
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(12, 24);
	endfunction

	function automatic int sender_gap();
		if ($urandom_range(0, 99) < 3)
			in_calm = !in_calm;
		if (in_calm || $urandom_range(0, 99) < 55)
			return 0;
		return idle_len();
	endfunction

	function automatic logic [CHAN_W-1:0] enabled_channel();
		logic [CHAN_W-1:0] c;
		c = 4'($urandom_range(0, EN_BITS - 1));
		if (gen_en == '0)
			return c;
		while (!gen_en[c[1:0]])
			c = 4'($urandom_range(0, EN_BITS - 1));
		return c;
	endfunction

	function automatic logic [CHAN_W-1:0] disabled_channel();
		logic [CHAN_W-1:0] c;
		c = 4'($urandom_range(0, EN_BITS - 1));
		while (gen_en[c[1:0]])
			c = 4'($urandom_range(0, EN_BITS - 1));
		return c;
	endfunction

	function automatic logic [LEN_W-1:0] frame_len();
		int top;
		top = ($urandom_range(0, 19) == 0) ? 300 : 12;
		if (top > gen_max)
			top = gen_max;
		return 12'($urandom_range(0, top));
	endfunction

	function automatic logic [BYTE_W-1:0] payload_value();
		// markers inside the payload are plain data
		if ($urandom_range(0, 9) == 0)
			return gen_marker;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void queue_frame(input logic [CHAN_W-1:0] ch,
			input logic [LEN_W-1:0] len, input int repeats, input frame_cut_t cut);
		logic [BYTE_W-1:0] end_byte;
		push_byte(gen_marker);
		for (int i = 0; i < repeats; i++)
			push_byte(gen_marker);
		push_byte({ch, len[11:8]});
		if (cut == CUT_HEADER)
			return;
		push_byte(len[7:0]);
		if (cut == CUT_LENGTH)
			return;
		for (int i = 0; i < len; i++)
			push_byte(payload_value());
		end_byte = gen_marker;
		if (cut == FULL_BAD_END) begin
			end_byte = 8'($urandom_range(0, 255));
			if (end_byte == gen_marker)
				end_byte = ~end_byte;
		end
		push_byte(end_byte);
	endfunction

	function automatic void queue_random_shape();
		int                r;
		int                n;
		logic [BYTE_W-1:0] b;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			queue_frame(4'($urandom_range(NUM_CHANNELS, 15)), 12'($urandom_range(0, 4095)),
				0, CUT_HEADER);
		end else if (r < 15 && gen_en != 4'hF) begin
			queue_frame(disabled_channel(), 12'($urandom_range(0, 4095)), 0, CUT_HEADER);
		end else if (r < 22 && gen_en != '0 && gen_max != 12'hFFF) begin
			queue_frame(enabled_channel(), 12'($urandom_range(gen_max + 1, 4095)), 0,
				CUT_LENGTH);
		end else if (r < 30) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				b = 8'($urandom_range(0, 255));
				if (b == gen_marker && $urandom_range(0, 9) != 0)
					b = b ^ 8'h01;
				push_byte(b);
			end
		end else if (r < 36) begin
			queue_frame(enabled_channel(), frame_len(), $urandom_range(1, 3), FULL_GOOD_END);
		end else if (r < 44) begin
			queue_frame(enabled_channel(), frame_len(), 0, FULL_BAD_END);
		end else begin
			queue_frame(enabled_channel(), frame_len(), 0, FULL_GOOD_END);
		end
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("channel_frame_receiver_tb: FAIL");
		$finish;
	end

	// monitor: checks results, tracks register writes and predicts each accepted byte
	always @(posedge clk) begin
		in_fire = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_deframed.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: kind %0d ch %0d byte %02h len %0d",
							result_kind, frame_channel, payload_byte, frame_length);
				end else begin
					got_evt = expected_deframed.pop_front();
					if (result_kind !== got_evt.kind || frame_channel !== got_evt.chan ||
							payload_byte !== got_evt.data || frame_length !== got_evt.len) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected kind %0d ch %0d byte %02h len %0d,",
								" got kind %0d ch %0d byte %02h len %0d"},
								got_evt.kind, got_evt.chan, got_evt.data, got_evt.len,
								result_kind, frame_channel, payload_byte, frame_length);
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MARKER: cur_marker = cfg_data[BYTE_W-1:0];
					REG_CH_EN: cur_enable = cfg_data[EN_BITS-1:0];
					REG_MAX_LEN: cur_max_len = cfg_data;
					default: ;
				endcase
			end
			in_fire = in_valid && !in_stall;
			if (in_fire)
				deframe_byte(rx_byte);
		end
	end

	// sender: bytes with random gaps, register writes and pauses only once the block is idle
	always @(negedge clk) begin
		if (arst_n) begin
			nx_valid = in_valid && !in_fire;
			nx_byte = rx_byte;
			nx_wr = 1'b0;
			if (!nx_valid && link_feed.size() != 0) begin
				if (link_feed[0].op == FEED_BYTE) begin
					if (send_gap > 0) begin
						send_gap--;
					end else begin
						head = link_feed.pop_front();
						nx_valid = 1'b1;
						nx_byte = head.val[BYTE_W-1:0];
						send_gap = sender_gap();
					end
				end else if (expected_deframed.size() != 0) begin
					settle = 0;
				end else if (settle < SETTLE_CYCLES) begin
					// bytes that give no result may still be in flight
					settle++;
				end else begin
					head = link_feed.pop_front();
					settle = 0;
					if (head.op == FEED_CFG) begin
						nx_wr = 1'b1;
						cfg_index <= head.idx;
						cfg_data <= head.val;
					end
				end
			end
			in_valid <= nx_valid;
			rx_byte <= nx_byte;
			cfg_wr_en <= nx_wr;
		end
	end

	// receiver: random stall runs with calm stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			out_calm = !out_calm;
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!out_calm && $urandom_range(0, 99) < 25) begin
			stall_left = idle_len() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		int                first;
		logic [BYTE_W-1:0] m;
		logic [EN_BITS-1:0] en;
		logic [LEN_W-1:0]  mx;

		// noise while hunting, then a repeated marker before a header on a disabled channel
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h7E);
		push_byte(8'h7E);
		push_byte(8'h0F);
		// upper data bits are dropped, the unused index does nothing
		push_cfg(REG_CH_EN, 12'hFF5);
		push_cfg(REG_UNUSED, 12'hABC);
		push_byte(8'h7E);
		push_byte(8'hF3);
		push_byte(8'h7E);
		push_byte(8'h10);
		// zero length goes straight to the end marker
		push_byte(8'h7E);
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'h7E);
		// two payload bytes then a wrong end byte
		push_byte(8'h7E);
		push_byte(8'h20);
		push_byte(8'h02);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h55);
		push_cfg(REG_MAX_LEN, 12'd0);
		push_byte(8'h7E);
		push_byte(8'h2F);
		push_byte(8'hFF);

		for (int p = 0; p < 12; p++) begin
			if (p % 4 == 0)
				push_drain();
			case (p)
				1: m = 8'h00;
				2: m = 8'hFF;
				default: m = ($urandom_range(0, 3) == 0) ? 8'h7E : 8'($urandom_range(0, 255));
			endcase
			push_cfg(REG_MARKER, {4'($urandom_range(0, 15)), m});
			if (p == 3)
				en = 4'h0;
			else if (p == 0 || p == 6)
				en = 4'hF;
			else
				en = 4'($urandom_range(1, 15));
			push_cfg(REG_CH_EN, {8'($urandom_range(0, 255)), en});
			if (p == 0 || p == 6)
				mx = 12'hFFF;
			else if (p == 4)
				mx = 12'd0;
			else if ($urandom_range(0, 1) == 0)
				mx = 12'($urandom_range(1, 40));
			else
				mx = 12'($urandom_range(0, 4095));
			push_cfg(REG_MAX_LEN, mx);
			if (p == 6)
				queue_frame(enabled_channel(), 12'h120, 0, FULL_GOOD_END);
			first = bytes_queued;
			while (bytes_queued - first < 60) begin
				queue_random_shape();
				if ($urandom_range(0, 49) == 0)
					push_drain();
			end
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (link_feed.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_deframed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_deframed.size() == 0)
			$display("channel_frame_receiver_tb: PASS");
		else
			$display("channel_frame_receiver_tb: FAIL");
		$finish;
	end

endmodule
